FILE: sv/grs_pkg.sv
// Package for the grid ring neighbour search core.
// Holds the fixed field widths, the stream packing offsets and the walker control type.
// No dependencies.
`default_nettype none
package grs_pkg;

	localparam int IDX_W  = 12;
	localparam int VAL_W  = 8;
	localparam int RAD_W  = 7;
	localparam int SIDE_W = 7;

	localparam int CI_LSB = 0;
	localparam int CV_LSB = CI_LSB + IDX_W;
	localparam int SI_LSB = CV_LSB + VAL_W;
	localparam int TV_LSB = SI_LSB + IDX_W;
	localparam int MR_LSB = TV_LSB + VAL_W;
	localparam int S_DATA_W = ((MR_LSB + RAD_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((IDX_W + 7) / 8) * 8;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic valid;
		logic in_map;
		logic last;
	} walk_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/grid_ring_neighbor_search_core.sv
// Grid ring neighbour search core. A write request stores one cell. A search request is
// accepted, then passes through the iterative divider that splits the start index into row
// and column, then walks one candidate per cycle through the single memory read port: ring
// r has 8r border cells, so a search that finds nothing at radius R walks 4R(R+1)
// candidates (16640 at R = 64) before the pipeline drains and the result is loaded. A hit
// ends the walk as soon as it is compared. The result sits in an output register, so a new
// request is taken while the previous result waits.
`default_nettype none
module grid_ring_neighbor_search_core import grs_pkg::*; #(
	parameter int MAX_SIDE  = 64,
	parameter int CELL_BITS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// cell_index, cell_value, start_index, target_value, max_radius, zero fill
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// action
	input  wire logic                s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// found_index, zero fill
	output logic [M_DATA_W-1:0]      m_tdata,
	// found
	output logic                     m_tuser,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [SIDE_W-1:0]   cfg_data
);

	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV    = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]           state_q;
	logic [SIDE_W-1:0]    map_side_q;
	logic [CELL_BITS-1:0] target_q;
	logic [SW-1:0]        rad_q;
	logic                 found_q;
	logic [IDX_W-1:0]     found_idx_q;
	logic                 m_tvalid_q;
	logic                 m_tuser_q;
	logic [IDX_W-1:0]     m_idx_q;
	logic                 valid_s2;
	logic                 in_map_s2;
	logic                 last_s2;
	logic [AW-1:0]        addr_s2;

	logic [SW-1:0]        side_use;
	logic                 accept;
	logic                 mem_we;
	logic                 div_start;
	logic                 div_done;
	logic [IDX_W-1:0]     div_quot;
	logic [SW-1:0]        div_rem;
	logic                 walk_start;
	logic                 hit;
	logic                 out_free;
	walk_ctrl_t           cand;
	logic [AW-1:0]        cand_addr;
	logic [CELL_BITS-1:0] rdata;
	logic [RAD_W-1:0]     in_rad;

	always_comb begin
		if (map_side_q == '0) begin
			side_use = SW'(1);
		end else if (int'(map_side_q) > MAX_SIDE) begin
			side_use = SW'(MAX_SIDE);
		end else begin
			side_use = SW'(map_side_q);
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign in_rad    = s_tdata[MR_LSB +: RAD_W];
	assign mem_we    = accept && (s_tuser == ACT_WRITE) &&
	                   (int'(s_tdata[CI_LSB +: IDX_W]) < DEPTH);
	assign div_start = accept && (s_tuser == ACT_SEARCH);
	assign walk_start = (state_q == ST_DIV) && div_done && (rad_q != '0);
	assign hit       = valid_s2 && in_map_s2 && (rdata == target_q);
	assign out_free  = !m_tvalid_q || m_tready;

	grs_divider #(.SW(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s_tdata[SI_LSB +: IDX_W]),
		.divisor  (side_use),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	grs_ring_walker #(.SW(SW), .AW(AW)) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (walk_start),
		.kill   (hit),
		.rad    (rad_q),
		.cx     (div_rem),
		.cy     (div_quot),
		.side   (side_use),
		.cand   (cand),
		.addr   (cand_addr)
	);

	grs_cell_mem #(.DEPTH(DEPTH), .AW(AW), .CELL_BITS(CELL_BITS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(s_tdata[CI_LSB +: IDX_W])),
		.wdata (CELL_BITS'(s_tdata[CV_LSB +: VAL_W])),
		.raddr (cand_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			map_side_q <= SIDE_W'(64);
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			valid_s2   <= 1'b0;
			in_map_s2  <= 1'b0;
			last_s2    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				map_side_q <= cfg_data;
			end
			valid_s2  <= cand.valid && !hit;
			in_map_s2 <= cand.in_map;
			last_s2   <= cand.last;
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						found_q <= 1'b0;
						state_q <= (rad_q == '0) ? ST_DONE : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (valid_s2 && last_s2) begin
						found_q <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= cand_addr;
		if (div_start) begin
			target_q <= CELL_BITS'(s_tdata[TV_LSB +: VAL_W]);
			if (int'(in_rad) > MAX_SIDE) begin
				rad_q <= SW'(MAX_SIDE);
			end else begin
				rad_q <= SW'(in_rad);
			end
		end
		if (hit) begin
			found_idx_q <= IDX_W'(addr_s2);
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_tuser_q <= found_q;
			m_idx_q   <= found_q ? found_idx_q : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = M_DATA_W'(m_idx_q);

	a_s2_only_searching: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (state_q == ST_SEARCH))
		else $error("candidate in compare stage outside a search");

	a_hit_ends_search: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SEARCH) && hit) |=> ((state_q == ST_DONE) && found_q && !valid_s2))
		else $error("match did not end the search");

	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[IDX_W-1:0] == '0))
		else $error("not-found result carries a non-zero index");

	a_hit_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
		(int'(m_tdata[IDX_W-1:0]) < (int'(side_use) * int'(side_use))))
		else $error("found index lies outside the map");

endmodule
`default_nettype wire

FILE: sv/grs_divider.sv
// Iterative restoring divider that splits a cell index into row and column.
// One quotient bit per cycle. Depends on grs_pkg.
`default_nettype none
module grs_divider import grs_pkg::*; #(
	parameter int SW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [IDX_W-1:0] dividend,
	input  wire logic [SW-1:0] divisor,
	output logic               done,
	output logic [IDX_W-1:0]   quot,
	output logic [SW-1:0]      rem
);

	localparam int CNT_W = $clog2(IDX_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [IDX_W-1:0] quo_q;
	logic [SW-1:0]    rem_q;
	logic [SW:0]      shifted;
	logic             take;

	always_comb begin
		shifted = {rem_q, quo_q[IDX_W-1]};
		take    = shifted >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(IDX_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[IDX_W-2:0], take};
			if (take) begin
				rem_q <= SW'(shifted - {1'b0, divisor});
			end else begin
				rem_q <= shifted[SW-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

FILE: sv/grs_ring_walker.sv
// Ring walker: steps through the border cells of square rings around a centre,
// one candidate per cycle, and registers its map address. Depends on grs_pkg.
`default_nettype none
module grs_ring_walker import grs_pkg::*; #(
	parameter int SW = 7,
	parameter int AW = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          kill,
	input  wire logic [SW-1:0] rad,
	input  wire logic [SW-1:0] cx,
	input  wire logic [IDX_W-1:0] cy,
	input  wire logic [SW-1:0] side,
	output walk_ctrl_t         cand,
	output logic [AW-1:0]      addr
);

	localparam int DW = SW + 1;
	localparam int CW = $clog2((2 ** IDX_W) + (2 ** SW)) + 1;
	localparam int PW = 2 * SW;

	logic                 run_q;
	logic [SW-1:0]        r_q;
	logic signed [DW-1:0] dx_q;
	logic signed [DW-1:0] dy_q;
	walk_ctrl_t           cand_s1;
	logic [AW-1:0]        addr_s1;

	logic signed [DW-1:0] rs;
	logic signed [DW-1:0] nrs;
	logic signed [DW-1:0] rs_next;
	logic                 edge_col;
	logic                 col_end;
	logic                 ring_end;
	logic                 fin;
	logic signed [CW-1:0] nx;
	logic signed [CW-1:0] ny;
	logic                 in_map;
	logic [PW-1:0]        prod;

	always_comb begin
		rs       = $signed({1'b0, r_q});
		nrs      = -rs;
		rs_next  = rs + DW'(1);
		edge_col = (dx_q == rs) || (dx_q == nrs);
		col_end  = (dy_q == rs);
		ring_end = col_end && (dx_q == rs);
		fin      = ring_end && (r_q == rad);
		nx       = $signed(CW'(cx)) + CW'(dx_q);
		ny       = $signed(CW'(cy)) + CW'(dy_q);
		in_map   = !nx[CW-1] && !ny[CW-1] &&
		           (nx < $signed(CW'(side))) && (ny < $signed(CW'(side)));
		prod     = ny[SW-1:0] * side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cand_s1 <= '0;
		end else begin
			cand_s1.valid  <= run_q && !kill;
			cand_s1.in_map <= in_map;
			cand_s1.last   <= fin;
			if (kill) begin
				run_q <= 1'b0;
			end else if (start) begin
				run_q <= (rad != '0);
			end else if (run_q && fin) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= AW'(prod + PW'(nx[SW-1:0]));
		if (start) begin
			r_q  <= SW'(1);
			dx_q <= -DW'(1);
			dy_q <= -DW'(1);
		end else if (run_q) begin
			if (ring_end) begin
				r_q  <= r_q + 1'b1;
				dx_q <= -rs_next;
				dy_q <= -rs_next;
			end else if (col_end) begin
				dx_q <= dx_q + DW'(1);
				dy_q <= nrs;
			end else if (edge_col) begin
				dy_q <= dy_q + DW'(1);
			end else begin
				dy_q <= rs;
			end
		end
	end

	assign cand = cand_s1;
	assign addr = addr_s1;

endmodule
`default_nettype wire

FILE: sv/grs_cell_mem.sv
// Cell store: one write port and one read port with registered read data.
// Does not depend on grs_pkg.
`default_nettype none
module grs_cell_mem #(
	parameter int DEPTH     = 4096,
	parameter int AW        = 12,
	parameter int CELL_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [CELL_BITS-1:0] wdata,
	input  wire logic [AW-1:0]        raddr,
	output logic [CELL_BITS-1:0]      rdata
);

	logic [CELL_BITS-1:0] mem [0:DEPTH-1];
	logic [CELL_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire
